// ===== hw/rtl/pidsv_pkg.sv =====
// pidsv_pkg: shared widths, register indexes and handshake types for the
// variable-interval PID step unit. No dependencies.

package pidsv_pkg;

	localparam int GAIN_W     = 32;	// Q16.16 gains
	localparam int MAXI_W     = 47;	// integral limit width
	localparam int MAXO_W     = 15;	// output limit width
	localparam int INTEG_W    = 48;	// integral accumulator, Q8.8 * us
	localparam int DT_W       = 16;	// elapsed microseconds
	localparam int DRIVE_W    = 16;	// Q8.8 drive
	localparam int TERM_SHIFT = 16;	// 24 fraction bits down to 8
	localparam int CHUNK_W    = 16;	// multiplier operand slice
	localparam int PMAG_W     = 61;	// saturated product magnitude, limit 2^60
	localparam int PROD_W     = PMAG_W + 1;

	localparam logic [PMAG_W-1:0] PROD_LIMIT = {1'b1, {(PMAG_W-1){1'b0}}};

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 47;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTEGRAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUTPUT   = 3'd4;

	// start pulse and result sign for the shared arithmetic units
	typedef struct packed {
		logic start;
		logic neg;
	} op_req_t;

endpackage

// ===== hw/rtl/pid_step_variable_dt_unit.sv =====
// pid_step_variable_dt_unit: fixed-point PID step with variable interval,
// anti-windup clamp and saturated output. Uses pidsv_pkg, pidsv_mul, pidsv_div.
// Each request makes four passes through the shared 32x16 multiplier and one
// through the 61-step divider; the next request is taken on return to idle.
// Reset clears state, the integral and previous error, and loads register defaults.

module pid_step_variable_dt_unit #(
	parameter int ERR_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [ERR_WIDTH-1:0]             error_sample,
	input  logic [pidsv_pkg::DT_W-1:0]              elapsed_us,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [pidsv_pkg::DRIVE_W-1:0]    drive,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [pidsv_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pidsv_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int EW1    = ERR_WIDTH + 1;
	localparam int MA_W   = (EW1 > pidsv_pkg::GAIN_W) ? EW1 : pidsv_pkg::GAIN_W;
	localparam int MB_W   = (EW1 > pidsv_pkg::INTEG_W) ? EW1 : pidsv_pkg::INTEG_W;
	localparam int TH_W   = ERR_WIDTH + pidsv_pkg::DT_W + 1;
	localparam int ISUM_W = ((TH_W > pidsv_pkg::INTEG_W) ? TH_W : pidsv_pkg::INTEG_W) + 1;
	localparam int SUM_W  = pidsv_pkg::PROD_W + 1;
	localparam int RND_W  = pidsv_pkg::TERM_SHIFT + pidsv_pkg::DRIVE_W;
	localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (pidsv_pkg::TERM_SHIFT - 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_LOAD  = 9'b000000010,
		ST_TSUM  = 9'b000000100,
		ST_CLAMP = 9'b000001000,
		ST_PMUL  = 9'b000010000,
		ST_IMUL  = 9'b000100000,
		ST_DMUL  = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic signed [pidsv_pkg::GAIN_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
	logic [pidsv_pkg::MAXI_W-1:0]        max_integral_q;
	logic [pidsv_pkg::MAXO_W-1:0]        max_output_q;

	// controller state and working registers
	logic signed [ERR_WIDTH-1:0]         prev_q;
	logic signed [pidsv_pkg::INTEG_W-1:0] integ_q;
	logic signed [ERR_WIDTH-1:0]         e_q;
	logic [pidsv_pkg::DT_W-1:0]          dt_q;
	logic signed [EW1-1:0]               dif_q;
	logic signed [ISUM_W-1:0]            isum_q;
	logic signed [SUM_W-1:0]             sum_q;
	logic                                out_valid_q;
	logic signed [pidsv_pkg::DRIVE_W-1:0] drive_q;

	logic                                in_take;
	logic                                out_free;
	logic signed [EW1-1:0]               esum;
	logic [EW1-1:0]                      esum_abs;
	logic [EW1-1:0]                      dif_abs;
	logic [ERR_WIDTH-1:0]                e_abs;
	logic [pidsv_pkg::INTEG_W-1:0]       integ_abs;
	logic [pidsv_pkg::GAIN_W-1:0]        gp_abs, gi_abs, gd_abs;

	pidsv_pkg::op_req_t                  mul_req, div_req;
	logic [MA_W-1:0]                     mul_a;
	logic [MB_W-1:0]                     mul_b;
	logic                                mul_done, div_done;
	logic [pidsv_pkg::PMAG_W-1:0]        mul_mag;
	logic signed [pidsv_pkg::PROD_W-1:0] mul_prod, div_quot;

	logic signed [ISUM_W-1:0]            mi_s;
	logic signed [ISUM_W-1:0]            integ_clamped;
	logic signed [SUM_W-1:0]             lim_s;
	logic [RND_W-1:0]                    rnd;
	logic signed [pidsv_pkg::DRIVE_W-1:0] drive_d;

	assign in_take  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign esum      = EW1'(e_q) + EW1'(prev_q);
	assign esum_abs  = esum[EW1-1] ? -esum : esum;
	assign dif_abs   = dif_q[EW1-1] ? -dif_q : dif_q;
	assign e_abs     = e_q[ERR_WIDTH-1] ? -e_q : e_q;
	assign integ_abs = integ_q[pidsv_pkg::INTEG_W-1] ? -integ_q : integ_q;
	assign gp_abs    = gain_prop_q[pidsv_pkg::GAIN_W-1] ? -gain_prop_q : gain_prop_q;
	assign gi_abs    = gain_integ_q[pidsv_pkg::GAIN_W-1] ? -gain_integ_q : gain_integ_q;
	assign gd_abs    = gain_deriv_q[pidsv_pkg::GAIN_W-1] ? -gain_deriv_q : gain_deriv_q;

	// sequencer: picks operands for the next multiply as the previous one lands
	always_comb begin
		state_d       = state_q;
		mul_req.start = 1'b0;
		mul_req.neg   = 1'b0;
		div_req.start = 1'b0;
		div_req.neg   = mul_prod[pidsv_pkg::PROD_W-1];
		mul_a         = '0;
		mul_b         = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_take) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				// trapezoid dt * (e + prev)
				mul_req.start = 1'b1;
				mul_req.neg   = esum[EW1-1];
				mul_a         = MA_W'(esum_abs);
				mul_b         = MB_W'(dt_q);
				state_d       = ST_TSUM;
			end
			ST_TSUM: begin
				if (mul_done) state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				mul_req.start = 1'b1;
				mul_req.neg   = gain_prop_q[pidsv_pkg::GAIN_W-1] ^ e_q[ERR_WIDTH-1];
				mul_a         = MA_W'(gp_abs);
				mul_b         = MB_W'(e_abs);
				state_d       = ST_PMUL;
			end
			ST_PMUL: begin
				mul_req.start = mul_done;
				mul_req.neg   = gain_integ_q[pidsv_pkg::GAIN_W-1] ^
						integ_q[pidsv_pkg::INTEG_W-1];
				mul_a         = MA_W'(gi_abs);
				mul_b         = MB_W'(integ_abs);
				if (mul_done) state_d = ST_IMUL;
			end
			ST_IMUL: begin
				mul_req.start = mul_done;
				mul_req.neg   = gain_deriv_q[pidsv_pkg::GAIN_W-1] ^ dif_q[EW1-1];
				mul_a         = MA_W'(gd_abs);
				mul_b         = MB_W'(dif_abs);
				if (mul_done) state_d = ST_DMUL;
			end
			ST_DMUL: begin
				div_req.start = mul_done;
				if (mul_done) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// anti-windup clamp against the configured limit
	always_comb begin
		mi_s = $signed(ISUM_W'(max_integral_q));
		if (isum_q > mi_s)
			integ_clamped = mi_s;
		else if (isum_q < -mi_s)
			integ_clamped = -mi_s;
		else
			integ_clamped = isum_q;
	end

	// output limit and round half up from 24 to 8 fraction bits
	always_comb begin
		lim_s = $signed(SUM_W'({max_output_q, {pidsv_pkg::TERM_SHIFT{1'b0}}}));
		rnd   = sum_q[RND_W-1:0] + ROUND_HALF;
		if (sum_q > lim_s)
			drive_d = $signed(pidsv_pkg::DRIVE_W'(max_output_q));
		else if (sum_q < -lim_s)
			drive_d = -$signed(pidsv_pkg::DRIVE_W'(max_output_q));
		else
			drive_d = $signed(rnd[RND_W-1:pidsv_pkg::TERM_SHIFT]);
	end

	pidsv_mul #(
		.A_W (MA_W),
		.B_W (MB_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.a_mag  (mul_a),
		.b_mag  (mul_b),
		.done   (mul_done),
		.mag    (mul_mag),
		.prod   (mul_prod)
	);

	pidsv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (mul_mag),
		.dvs    (dt_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			gain_prop_q    <= '0;
			gain_integ_q   <= '0;
			gain_deriv_q   <= '0;
			max_integral_q <= '1;
			max_output_q   <= '1;
			prev_q         <= '0;
			integ_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pidsv_pkg::CFG_GAIN_PROP:
						gain_prop_q <= cfg_data[pidsv_pkg::GAIN_W-1:0];
					pidsv_pkg::CFG_GAIN_INTEG:
						gain_integ_q <= cfg_data[pidsv_pkg::GAIN_W-1:0];
					pidsv_pkg::CFG_GAIN_DERIV:
						gain_deriv_q <= cfg_data[pidsv_pkg::GAIN_W-1:0];
					pidsv_pkg::CFG_MAX_INTEGRAL:
						max_integral_q <= cfg_data[pidsv_pkg::MAXI_W-1:0];
					pidsv_pkg::CFG_MAX_OUTPUT:
						max_output_q <= cfg_data[pidsv_pkg::MAXO_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_CLAMP)
				integ_q <= integ_clamped[pidsv_pkg::INTEG_W-1:0];
			if (state_q == ST_DONE && out_free) begin
				prev_q      <= e_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			e_q  <= error_sample;
			dt_q <= (elapsed_us == '0) ? pidsv_pkg::DT_W'(1) : elapsed_us;
		end
		if (state_q == ST_LOAD)
			dif_q <= EW1'(e_q) - EW1'(prev_q);
		// floor of half the trapezoid is an arithmetic shift
		if (state_q == ST_TSUM && mul_done)
			isum_q <= $signed(ISUM_W'(integ_q)) + $signed(mul_prod[ISUM_W:1]);
		if (state_q == ST_PMUL && mul_done)
			sum_q <= SUM_W'(mul_prod);
		if (state_q == ST_IMUL && mul_done)
			sum_q <= sum_q + SUM_W'(mul_prod);
		if (state_q == ST_DIV && div_done)
			sum_q <= sum_q + SUM_W'(div_quot);
		if (state_q == ST_DONE && out_free)
			drive_q <= drive_d;
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final step");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_TSUM || state_q == ST_PMUL ||
			state_q == ST_IMUL || state_q == ST_DMUL))
		else $error("multiplier finished outside a multiply step");

	a_prev_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(prev_q) |-> $past(state_q == ST_DONE))
		else $error("previous error changed without a result");

endmodule

// ===== hw/rtl/pidsv_mul.sv =====
// pidsv_mul: sign-magnitude multiplier, one A_W x 16 slice per cycle,
// result magnitude saturated at 2^60. Depends on pidsv_pkg.

module pidsv_mul #(
	parameter int A_W = 32,
	parameter int B_W = 48
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pidsv_pkg::op_req_t                     req,
	input  logic [A_W-1:0]                         a_mag,
	input  logic [B_W-1:0]                         b_mag,
	output logic                                   done,
	output logic [pidsv_pkg::PMAG_W-1:0]           mag,
	output logic signed [pidsv_pkg::PROD_W-1:0]    prod
);

	localparam int NCH   = (B_W + pidsv_pkg::CHUNK_W - 1) / pidsv_pkg::CHUNK_W;
	localparam int BP_W  = NCH * pidsv_pkg::CHUNK_W;
	localparam int ACC_W = A_W + BP_W;
	localparam int PP_W  = A_W + pidsv_pkg::CHUNK_W;
	localparam int CNT_W = $clog2(NCH + 1);

	logic [A_W-1:0]                      a_q;
	logic [BP_W-1:0]                     b_q;
	logic [ACC_W-1:0]                    acc_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic                                busy_q;
	logic                                neg_q;
	logic                                done_q;
	logic [pidsv_pkg::PMAG_W-1:0]        mag_q;
	logic signed [pidsv_pkg::PROD_W-1:0] prod_q;

	logic [PP_W-1:0]                     pp;
	logic [pidsv_pkg::PMAG_W-1:0]        sat_mag;

	assign pp = a_q * b_q[BP_W-1 -: pidsv_pkg::CHUNK_W];

	// anything at or above 2^60 clips to the limit
	assign sat_mag = (|acc_q[ACC_W-1:pidsv_pkg::PMAG_W-1]) ? pidsv_pkg::PROD_LIMIT
			: acc_q[pidsv_pkg::PMAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NCH);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// most significant slice first, so the partial sum just shifts up
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= a_mag;
			b_q   <= BP_W'(b_mag);
			neg_q <= req.neg;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				acc_q <= (acc_q << pidsv_pkg::CHUNK_W) + ACC_W'(pp);
				b_q   <= b_q << pidsv_pkg::CHUNK_W;
			end else begin
				mag_q  <= sat_mag;
				prod_q <= neg_q ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});
			end
		end
	end

	assign done = done_q;
	assign mag  = mag_q;
	assign prod = prod_q;

endmodule

// ===== hw/rtl/pidsv_div.sv =====
// pidsv_div: restoring radix-2 divider, one quotient bit per cycle,
// quotient truncated toward zero. Depends on pidsv_pkg.

module pidsv_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pidsv_pkg::op_req_t                     req,
	input  logic [pidsv_pkg::PMAG_W-1:0]           num,
	input  logic [pidsv_pkg::DT_W-1:0]             dvs,
	output logic                                   done,
	output logic signed [pidsv_pkg::PROD_W-1:0]    quot
);

	localparam int NUM_W = pidsv_pkg::PMAG_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]                    num_q;
	logic [NUM_W-1:0]                    quo_q;
	logic [pidsv_pkg::DT_W-1:0]          rem_q;
	logic [pidsv_pkg::DT_W-1:0]          dvs_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic                                busy_q;
	logic                                neg_q;
	logic                                done_q;
	logic signed [pidsv_pkg::PROD_W-1:0] quot_q;

	logic [pidsv_pkg::DT_W:0]            rem_sh;
	logic                                fits;
	logic [pidsv_pkg::DT_W:0]            rem_sub;

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= num;
			dvs_q <= dvs;
			neg_q <= req.neg;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				num_q <= num_q << 1;
				quo_q <= {quo_q[NUM_W-2:0], fits};
				rem_q <= fits ? rem_sub[pidsv_pkg::DT_W-1:0] : rem_sh[pidsv_pkg::DT_W-1:0];
			end else begin
				quot_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== verif/pid_step_variable_dt_unit_tb.sv =====
`timescale 1ns / 100ps
// pid_step_variable_dt_unit_tb: self-checking bench for the variable-interval PID step unit.
// Depends on pidsv_pkg and pid_step_variable_dt_unit; scoreboard predicts drive per request.

module pid_step_variable_dt_unit_tb;
	import pidsv_pkg::*;

	localparam int ERR_W        = 16;
	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 4;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 185;
	localparam int HOLD_CYCLES  = 1200;
	localparam int TAIL_CYCLES  = 150;
	localparam int LIMIT_NS     = 40_000_000;
	localparam int PAD_W        = CFG_DATA_W - GAIN_W;

	// indexes past the register list, which the block ignores
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          in_valid     = 1'b0;
	logic                          in_stall;
	logic signed [ERR_W-1:0]       error_sample = '0;
	logic [DT_W-1:0]               elapsed_us   = '0;
	logic                          out_valid;
	logic                          out_stall    = 1'b0;
	logic signed [DRIVE_W-1:0]     drive;
	logic                          cfg_valid    = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index    = '0;
	logic [CFG_DATA_W-1:0]         cfg_data     = '0;

	bit hold_req  = 1'b0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	class drive_scoreboard;
		typedef struct {
			logic signed [DRIVE_W-1:0] drive;
			logic signed [ERR_W-1:0]   err;
			logic [DT_W-1:0]           dt;
			int unsigned               seq;
		} drive_expect_t;

		logic signed [GAIN_W-1:0]  kp, ki, kd;
		logic [MAXI_W-1:0]         integ_limit;
		logic [MAXO_W-1:0]         out_limit;
		logic signed [ERR_W-1:0]   last_err;
		logic signed [INTEG_W-1:0] integ;
		drive_expect_t             drive_q[$];
		int unsigned               n_req;
		int unsigned               n_fail;

		function new();
			kp = '0;
			ki = '0;
			kd = '0;
			integ_limit = '1;
			out_limit = '1;
			last_err = '0;
			integ = '0;
			n_req = 0;
			n_fail = 0;
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
			CFG_GAIN_PROP:    kp = val[GAIN_W-1:0];
			CFG_GAIN_INTEG:   ki = val[GAIN_W-1:0];
			CFG_GAIN_DERIV:   kd = val[GAIN_W-1:0];
			CFG_MAX_INTEGRAL: integ_limit = val[MAXI_W-1:0];
			CFG_MAX_OUTPUT:   out_limit = val[MAXO_W-1:0];
			default: ;
			endcase
		endfunction

		// gain times operand, magnitude held at 2^60
		static function longint gain_product(longint g, longint x);
			logic signed [127:0] ga, xa, p;
			logic [127:0]        mag;
			ga = g;
			xa = x;
			p = ga * xa;
			mag = p[127] ? -p : p;
			if (mag > PROD_LIMIT)
				mag = PROD_LIMIT;
			return p[127] ? -longint'(mag[63:0]) : longint'(mag[63:0]);
		endfunction

		function void note_request(logic signed [ERR_W-1:0] err, logic [DT_W-1:0] elapsed);
			longint        e, le, dt, acc, lim_i, total, lim_o;
			drive_expect_t x;
			e = err;
			le = last_err;
			dt = (elapsed == 0) ? 1 : elapsed;
			// trapezoid step, floor of the half
			acc = integ + ((dt * (e + le)) >>> 1);
			lim_i = integ_limit;
			if (acc > lim_i)
				acc = lim_i;
			else if (acc < -lim_i)
				acc = -lim_i;
			integ = acc[INTEG_W-1:0];
			total = gain_product(kp, e) + gain_product(ki, acc) + gain_product(kd, e - le) / dt;
			lim_o = longint'(out_limit) <<< TERM_SHIFT;
			if (total > lim_o)
				x.drive = $signed({1'b0, out_limit});
			else if (total < -lim_o)
				x.drive = -$signed({1'b0, out_limit});
			else
				x.drive = DRIVE_W'((total + 32768) >>> TERM_SHIFT);
			x.err = err;
			x.dt = elapsed;
			x.seq = n_req;
			n_req++;
			last_err = err;
			drive_q.push_back(x);
		endfunction

		task report(string msg);
			n_fail++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(logic signed [DRIVE_W-1:0] got);
			drive_expect_t x;
			if (drive_q.size() == 0) begin
				report($sformatf("drive %0d with no request outstanding", got));
				return;
			end
			x = drive_q.pop_front();
			if (got !== x.drive)
				report($sformatf("request %0d (error %0d, dt %0d): drive %0d, expected %0d",
					x.seq, x.err, x.dt, got, x.drive));
		endtask
	endclass

	drive_scoreboard sb = new();

	always #(HALF_PERIOD) clk = ~clk;

	pid_step_variable_dt_unit #(
		.ERR_WIDTH(ERR_W)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.error_sample (error_sample),
		.elapsed_us   (elapsed_us),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive        (drive),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain(int unsigned span);
		int unsigned r;
		r = $urandom_range(0, 15);
		case (r)
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return '0;
		3: return $urandom;
		default: return GAIN_W'(int'($urandom_range(0, 2 * span)) - int'(span));
		endcase
	endfunction

	function automatic logic signed [ERR_W-1:0] pick_error();
		case ($urandom_range(0, 9))
		0: return 16'sh7FFF;
		1: return 16'sh8000;
		2: return ERR_W'(int'($urandom_range(0, 1024)) - 512);
		3: return '0;
		default: return ERR_W'($urandom);
		endcase
	endfunction

	function automatic logic [DT_W-1:0] pick_elapsed();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		2, 3: return DT_W'($urandom);
		default: return DT_W'($urandom_range(1, 64));
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(drive);
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int unsigned burst;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall = 1'b0;
			end else if (recv_calm || !arst_n) begin
				out_stall = 1'b0;
			end else begin
				burst = gap_len();
				if (burst == 0) begin
					out_stall = 1'b0;
				end else begin
					out_stall = 1'b1;
					repeat (burst - 1) @(negedge clk);
					out_stall = 1'b0;
				end
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("pid_step_variable_dt_unit_tb NOT OK");
		$finish;
	end

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.apply_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// gains only use the low bits, so the upper ones carry noise
	function automatic logic [CFG_DATA_W-1:0] gain_word(logic [GAIN_W-1:0] g);
		return {PAD_W'($urandom), g};
	endfunction

	task automatic program_all(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
			input logic [GAIN_W-1:0] kd, input logic [MAXI_W-1:0] mi, input logic [MAXO_W-1:0] mo);
		program_reg(CFG_GAIN_PROP, gain_word(kp));
		program_reg(CFG_GAIN_INTEG, gain_word(ki));
		program_reg(CFG_GAIN_DERIV, gain_word(kd));
		program_reg(CFG_MAX_INTEGRAL, mi);
		program_reg(CFG_MAX_OUTPUT, {32'($urandom), mo});
	endtask

	task automatic send_request(input logic signed [ERR_W-1:0] err, input logic [DT_W-1:0] elapsed);
		int unsigned gap;
		gap = send_calm ? 0 : gap_len();
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		error_sample = err;
		elapsed_us = elapsed;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(err, elapsed);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.drive_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register defaults: zero gains, so drive stays at zero
		send_request(16'sh7FFF, 16'd0);
		send_request(16'sh8000, 16'hFFFF);
		wait_idle();

		// unit proportional gain, tiny integral gain, modest derivative gain
		program_all(32'h0001_0000, 32'h0000_0001, 32'h0000_0100, '1, '1);
		program_reg(CFG_SPARE_FIRST, CFG_DATA_W'({$urandom, $urandom}));
		program_reg(CFG_SPARE_LAST, '1);
		send_request(16'sh0000, 16'd0);
		send_request(16'sh0100, 16'd1);
		send_request(-16'sh0100, 16'd0);
		send_request(16'sh7FFF, 16'd1);
		send_request(16'sh8000, 16'd1);
		send_request(16'sh7FFF, 16'hFFFF);
		send_request(16'sh8000, 16'hFFFF);
		send_request(16'sh0001, 16'd2);
		send_request(-16'sh0001, 16'd3);
		send_request(16'sh0000, 16'd0);
		wait_idle();

		// gain extremes, the integral product runs into its limit
		program_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1);
		send_request(16'sh7FFF, 16'hFFFF);
		send_request(16'sh7FFF, 16'hFFFF);
		send_request(16'sh8000, 16'hFFFF);
		send_request(16'sh8000, 16'hFFFF);
		wait_idle();

		// zero output limit, then zero integral limit
		program_reg(CFG_MAX_OUTPUT, '0);
		send_request(16'sh3039, 16'd7);
		send_request(-16'sh012C, 16'd0);
		wait_idle();
		program_reg(CFG_MAX_INTEGRAL, '0);
		program_reg(CFG_MAX_OUTPUT, CFG_DATA_W'(16'h7FFF));
		send_request(16'sh7FFF, 16'd100);
		send_request(-16'sh0005, 16'd9);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			send_calm = (p == 2) || (p == 5);
			recv_calm = (p == 2);
			if (p == 0 || $urandom_range(0, 1))
				program_reg(CFG_GAIN_PROP, gain_word(pick_gain(1 << 17)));
			if (p == 0 || $urandom_range(0, 1))
				program_reg(CFG_GAIN_INTEG, gain_word(pick_gain(64)));
			if (p == 0 || $urandom_range(0, 1))
				program_reg(CFG_GAIN_DERIV, gain_word(pick_gain(1 << 16)));
			if (p == 0 || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 7))
				0: program_reg(CFG_MAX_INTEGRAL, '0);
				1: program_reg(CFG_MAX_INTEGRAL, '1);
				2: program_reg(CFG_MAX_INTEGRAL, CFG_DATA_W'({$urandom, $urandom}));
				default: program_reg(CFG_MAX_INTEGRAL, CFG_DATA_W'($urandom_range(0, 1 << 24)));
				endcase
			end
			if (p == 0 || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 5))
				0: program_reg(CFG_MAX_OUTPUT, '0);
				1: program_reg(CFG_MAX_OUTPUT, CFG_DATA_W'(15'h7FFF));
				default: program_reg(CFG_MAX_OUTPUT, CFG_DATA_W'({$urandom, $urandom}));
				endcase
			end
			if ($urandom_range(0, 3) == 0)
				program_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
					CFG_DATA_W'({$urandom, $urandom}));
			// the result side holds off while requests keep coming
			if (p == 4)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS)
				send_request(pick_error(), pick_elapsed());
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.drive_q.size() != 0)
			sb.report($sformatf("%0d drive results never arrived", sb.drive_q.size()));
		if (sb.n_fail == 0)
			$display("pid_step_variable_dt_unit_tb OK");
		else
			$display("pid_step_variable_dt_unit_tb NOT OK");
		$finish;
	end

endmodule
